[hw/rtl/pfds_pkg.sv]
// ----------------------------------------------------------------------------
// pfds_pkg
// Shared constants and types of the periodic field direct-sum unit.
// ----------------------------------------------------------------------------
package pfds_pkg;

    localparam int MAX_SOURCES = 1024;
    localparam int ADDR_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_RATIO_SQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_FACTOR  = 2'd2;

    localparam logic [31:0] INV_LENGTH_RST   = 32'd16777216;
    localparam logic [31:0] EPS_RATIO_SQ_RST = 32'd10737418;
    localparam logic [31:0] NORM_FACTOR_RST  = 32'd268435456;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // kernel clip bound, 2^39 in units 2^-32
    localparam logic [39:0] KCLIP = 40'h80_0000_0000;

    typedef struct packed {
        logic [31:0] inv_length;
        logic [31:0] eps_ratio_sq;
        logic [31:0] norm_factor;
    } pfds_cfg_t;

endpackage

[hw/rtl/pfds_if.sv]
// ----------------------------------------------------------------------------
// pfds_if
// Channel interfaces: request beats, result beats, configuration writes.
// ----------------------------------------------------------------------------
interface pfds_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] position;
    logic [31:0] weight;
    logic        first_source;

    modport source (output valid, command, position, weight, first_source, input ready);
    modport sink   (input valid, command, position, weight, first_source, output ready);
endinterface

interface pfds_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] field_value;
    logic        saturated;
    logic        store_overflow;

    modport source (output valid, field_value, saturated, store_overflow, input ready);
    modport sink   (input valid, field_value, saturated, store_overflow, output ready);
endinterface

interface pfds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfds_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/pfds_kernel.sv]
// ----------------------------------------------------------------------------
// pfds_kernel
// Fully pipelined per-source kernel: wrap, sqrt, divide, weight. One source
// per cycle in, one term per cycle out.
// ----------------------------------------------------------------------------
module pfds_kernel (
    input  logic                clk,
    input  logic                rst_n,
    input  pfds_pkg::pfds_cfg_t cfg_regs,
    input  logic [31:0]         target,
    input  logic                src_valid,
    input  logic [31:0]         src_position,
    input  logic [31:0]         src_weight,
    output logic                term_valid,
    output logic signed [63:0]  term
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 40;
    localparam int KLAT      = 4 + SQ_STEPS + 1 + DIV_STEPS + 2;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] w;
        logic [63:0] num;
        logic [63:0] s;
        logic [31:0] root;
        logic [33:0] rem;
    } sq_stage_t;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] w;
        logic [63:0] num;
        logic [31:0] r;
        logic [32:0] rem;
        logic [39:0] q;
        logic        ovf;
        logic        rzero;
    } dv_stage_t;

    logic [KLAT-1:0] vpipe_reg;

    logic [32:0] d1_reg;
    logic [31:0] w1_reg;
    logic [31:0] z2_reg;
    logic [31:0] w2_reg;
    logic [31:0] z3_reg;
    logic [31:0] w3_reg;
    logic [63:0] sq3_reg;
    logic [63:0] num3_reg;

    logic [39:0] p2;
    logic [31:0] mag;
    logic [63:0] sq_c;
    logic [63:0] nm_c;

    sq_stage_t sqs [0:SQ_STEPS];
    dv_stage_t dvs [0:DIV_STEPS];

    logic [39:0]        h;
    logic signed [41:0] hs;
    logic signed [41:0] zx;
    logic signed [41:0] kf;
    logic signed [41:0] kc;
    logic signed [32:0] k8_reg;
    logic [31:0]        wk_reg;
    logic signed [64:0] pm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else
            vpipe_reg <= {vpipe_reg[KLAT-2:0], src_valid};
    end

    assign term_valid = vpipe_reg[KLAT-1];

    // front: separation, wrap, squares
    always_comb
    begin
        p2   = {{7{d1_reg[32]}}, d1_reg} * {8'd0, cfg_regs.inv_length};
        mag  = z2_reg[31] ? (32'd0 - z2_reg) : z2_reg;
        sq_c = {32'd0, mag} * {32'd0, mag};
        nm_c = {32'd0, mag} * {32'd0, cfg_regs.norm_factor};
    end

    always_ff @(posedge clk)
    begin
        d1_reg   <= {target[31], target} - {src_position[31], src_position};
        w1_reg   <= src_weight;
        z2_reg   <= p2[39:8];
        w2_reg   <= w1_reg;
        z3_reg   <= z2_reg;
        w3_reg   <= w2_reg;
        sq3_reg  <= sq_c;
        num3_reg <= {nm_c[62:0], 1'b0};
        sqs[0].z    <= z3_reg;
        sqs[0].w    <= w3_reg;
        sqs[0].num  <= num3_reg;
        sqs[0].s    <= {4'd0, sq3_reg[63:4]} + {2'd0, cfg_regs.eps_ratio_sq, 30'd0};
        sqs[0].root <= '0;
        sqs[0].rem  <= '0;
    end

    // digit-by-digit square root, one result bit per stage
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        logic [33:0] rem_sh;
        logic [33:0] trial;

        always_comb
        begin
            rem_sh = {sqs[i].rem[31:0], sqs[i].s[2*(SQ_STEPS-1-i)+1 -: 2]};
            trial  = {sqs[i].root, 2'b01};
        end

        always_ff @(posedge clk)
        begin
            sqs[i+1].z   <= sqs[i].z;
            sqs[i+1].w   <= sqs[i].w;
            sqs[i+1].num <= sqs[i].num;
            sqs[i+1].s   <= sqs[i].s;
            if (rem_sh >= trial)
            begin
                sqs[i+1].rem  <= rem_sh - trial;
                sqs[i+1].root <= {sqs[i].root[30:0], 1'b1};
            end
            else
            begin
                sqs[i+1].rem  <= rem_sh;
                sqs[i+1].root <= {sqs[i].root[30:0], 1'b0};
            end
        end
    end

    // divider setup: quotient of 2^40 or more is clipped anyway
    always_ff @(posedge clk)
    begin
        dvs[0].z     <= sqs[SQ_STEPS].z;
        dvs[0].w     <= sqs[SQ_STEPS].w;
        dvs[0].num   <= sqs[SQ_STEPS].num;
        dvs[0].r     <= sqs[SQ_STEPS].root;
        dvs[0].rem   <= {9'd0, sqs[SQ_STEPS].num[63:40]};
        dvs[0].q     <= '0;
        dvs[0].ovf   <= {8'd0, sqs[SQ_STEPS].num[63:40]} >= sqs[SQ_STEPS].root;
        dvs[0].rzero <= (sqs[SQ_STEPS].root == 32'd0);
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [32:0] rem_sh;

        always_comb
        begin
            rem_sh = {dvs[i].rem[31:0], dvs[i].num[DIV_STEPS-1-i]};
        end

        always_ff @(posedge clk)
        begin
            dvs[i+1].z     <= dvs[i].z;
            dvs[i+1].w     <= dvs[i].w;
            dvs[i+1].num   <= dvs[i].num;
            dvs[i+1].r     <= dvs[i].r;
            dvs[i+1].ovf   <= dvs[i].ovf;
            dvs[i+1].rzero <= dvs[i].rzero;
            if (rem_sh >= {1'b0, dvs[i].r})
            begin
                dvs[i+1].rem <= rem_sh - {1'b0, dvs[i].r};
                dvs[i+1].q   <= {dvs[i].q[38:0], 1'b1};
            end
            else
            begin
                dvs[i+1].rem <= rem_sh;
                dvs[i+1].q   <= {dvs[i].q[38:0], 1'b0};
            end
        end
    end

    // kernel value, clip, floor to 2^-24, weight
    always_comb
    begin
        if (dvs[DIV_STEPS].rzero)
            h = '0;
        else if (dvs[DIV_STEPS].ovf || dvs[DIV_STEPS].q > pfds_pkg::KCLIP)
            h = pfds_pkg::KCLIP;
        else
            h = dvs[DIV_STEPS].q;
        hs = $signed({2'b00, h});
        zx = 42'($signed(dvs[DIV_STEPS].z));
        kf = dvs[DIV_STEPS].z[31] ? (-hs - zx) : (hs - zx);
        if (kf > $signed({2'b00, pfds_pkg::KCLIP}))
            kc = $signed({2'b00, pfds_pkg::KCLIP});
        else if (kf < -$signed({2'b00, pfds_pkg::KCLIP}))
            kc = -$signed({2'b00, pfds_pkg::KCLIP});
        else
            kc = kf;
        pm = $signed(wk_reg) * k8_reg;
    end

    always_ff @(posedge clk)
    begin
        k8_reg <= kc[40:8];
        wk_reg <= dvs[DIV_STEPS].w;
        term   <= {{15{pm[64]}}, pm[64:16]};
    end

endmodule

[hw/rtl/periodic_field_direct_sum_unit.sv]
// ----------------------------------------------------------------------------
// periodic_field_direct_sum_unit
// Direct-sum periodic smoothed field over a loaded source set.
// ----------------------------------------------------------------------------
// A load beat stores a source (position, weight); with first_source set it
// restarts the set. Loads past 1024 sources are dropped and reported on
// every later result as store_overflow until a restart.
// An evaluate beat walks every stored source through the kernel pipeline,
// one source per cycle from the source memory. For N stored sources the
// result passes through N memory reads, the registered read, the 79-stage
// kernel (32 square-root stages, 40 divider stages), the accumulator and
// the output register; the next beat can be taken as soon as the result
// is valid. An empty store skips the walk and goes straight to the output.
// The block takes one beat at a time; a finished result sits in the output
// register and the next beat is taken while it waits. No clearing pass: only
// written entries are read.
// ----------------------------------------------------------------------------
module periodic_field_direct_sum_unit (
    input  logic        clk,
    input  logic        rst_n,
    pfds_req_if.sink    req,
    pfds_rsp_if.source  rsp,
    pfds_cfg_if.sink    cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    pfds_pkg::pfds_cfg_t cfg_reg;

    // source set bookkeeping
    logic [pfds_pkg::CNT_W-1:0] count_reg;
    logic                       ovf_reg;

    // evaluate walk
    logic [31:0]                target_reg;
    logic [pfds_pkg::CNT_W-1:0] total_reg;
    logic [pfds_pkg::CNT_W-1:0] issue_reg;
    logic [pfds_pkg::CNT_W-1:0] done_reg;
    logic signed [63:0]         acc_reg;

    // source memory: {position, weight}
    logic [63:0]                 src_mem [0:pfds_pkg::MAX_SOURCES-1];
    logic                        rd_en_reg;
    logic [pfds_pkg::ADDR_W-1:0] rd_addr_reg;
    logic                        rd_valid_reg;
    logic [63:0]                 rd_data_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] out_field_reg;
    logic        out_sat_reg;
    logic        out_ovf_reg;

    logic                       accept;
    logic [pfds_pkg::CNT_W-1:0] load_base;
    logic                       load_fits;
    logic                       wr_en;
    logic signed [55:0]         qv;
    logic                       q_hi;
    logic                       q_lo;

    logic               term_valid;
    logic signed [63:0] term;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.field_value    = out_field_reg;
    assign rsp.saturated      = out_sat_reg;
    assign rsp.store_overflow = out_ovf_reg;

    // a restart always finds room, so its slot is zero
    always_comb
    begin
        load_base = req.first_source ? '0 : count_reg;
        load_fits = load_base < pfds_pkg::CNT_W'(pfds_pkg::MAX_SOURCES);
        wr_en     = accept && (req.command == pfds_pkg::CMD_LOAD) && load_fits;
        qv        = acc_reg[63:8];
        q_hi      = qv > 56'sd2147483647;
        q_lo      = qv < -56'sd2147483648;
    end

    // memory: one write port for loads, one registered read for the walk
    always_ff @(posedge clk)
    begin
        if (wr_en)
            src_mem[load_base[pfds_pkg::ADDR_W-1:0]] <= {req.position, req.weight};
        if (rd_en_reg)
            rd_data_reg <= src_mem[rd_addr_reg];
    end

    // configuration writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_length   <= pfds_pkg::INV_LENGTH_RST;
            cfg_reg.eps_ratio_sq <= pfds_pkg::EPS_RATIO_SQ_RST;
            cfg_reg.norm_factor  <= pfds_pkg::NORM_FACTOR_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfds_pkg::CFG_INV_LENGTH:   cfg_reg.inv_length   <= cfg.data;
                pfds_pkg::CFG_EPS_RATIO_SQ: cfg_reg.eps_ratio_sq <= cfg.data;
                pfds_pkg::CFG_NORM_FACTOR:  cfg_reg.norm_factor  <= cfg.data;
                default: ;
            endcase
        end
    end

    // control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            issue_reg     <= '0;
            done_reg      <= '0;
            acc_reg       <= '0;
            target_reg    <= '0;
            rd_en_reg     <= 1'b0;
            rd_addr_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_field_reg <= '0;
            out_sat_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            // one memory read per cycle until every source is issued
            rd_en_reg    <= (state_reg == ST_RUN) && (issue_reg != total_reg);
            rd_valid_reg <= rd_en_reg;
            if (rsp.ready && state_reg != ST_FINISH)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.command == pfds_pkg::CMD_EVAL)
                        begin
                            target_reg <= req.position;
                            total_reg  <= count_reg;
                            issue_reg  <= '0;
                            done_reg   <= '0;
                            acc_reg    <= '0;
                            state_reg  <= (count_reg == '0) ? ST_FINISH : ST_RUN;
                        end
                        else if (load_fits)
                        begin
                            count_reg <= load_base + 1'b1;
                            if (req.first_source)
                                ovf_reg <= 1'b0;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end

                ST_RUN:
                begin
                    if (issue_reg != total_reg)
                    begin
                        rd_addr_reg <= issue_reg[pfds_pkg::ADDR_W-1:0];
                        issue_reg   <= issue_reg + 1'b1;
                    end
                    if (term_valid)
                    begin
                        acc_reg  <= acc_reg + term;
                        done_reg <= done_reg + 1'b1;
                        if (pfds_pkg::CNT_W'(done_reg + 1'b1) == total_reg)
                            state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sat_reg   <= q_hi || q_lo;
                        out_ovf_reg   <= ovf_reg;
                        if (q_hi)
                            out_field_reg <= 32'h7FFF_FFFF;
                        else if (q_lo)
                            out_field_reg <= 32'h8000_0000;
                        else
                            out_field_reg <= qv[31:0];
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    pfds_kernel u_kernel (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_regs     (cfg_reg),
        .target       (target_reg),
        .src_valid    (rd_valid_reg),
        .src_position (rd_data_reg[63:32]),
        .src_weight   (rd_data_reg[31:0]),
        .term_valid   (term_valid),
        .term         (term)
    );

    // terms never outrun the reads that produced them
    a_done_le_issue: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg <= issue_reg)
        else $error("more terms summed than sources issued");

    // kernel output only appears during a walk
    a_term_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        term_valid |-> (state_reg == ST_RUN))
        else $error("kernel term outside walk");

    // a fitting append load bumps the count by one
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == pfds_pkg::CMD_LOAD && !req.first_source && load_fits)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("source count not advanced on load");

    // a finished result is not lost while the output is stalled
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !rsp.ready)
        |=> (state_reg == ST_FINISH))
        else $error("result left finish state while output blocked");

endmodule
